### rtl/core/butterworth_lowpass_order4_macros.svh
// Assertion macros for the fourth-order low-pass filter checker
`ifndef BUTTERWORTH_LOWPASS_ORDER4_MACROS_SVH
`define BUTTERWORTH_LOWPASS_ORDER4_MACROS_SVH

// same-cycle implication, off during reset
`define BWLP4_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define BWLP4_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

// next-cycle implication, checked during reset too
`define BWLP4_ASSERT_NXT_ALL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) \
        (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/bwlp4_pkg.sv
// Types, widths and arithmetic helpers for the fourth-order low-pass filter
`timescale 1ns / 1ps
package bwlp4_pkg;

    localparam int SAMPLE_BITS     = 16;
    localparam int STATE_FRAC_BITS = 24;
    localparam int GAIN_BITS       = 40;
    localparam int COEF_BITS       = 32;
    localparam int COEF_FRAC       = 28;
    localparam int HIST_BITS       = 48;
    localparam int TAPS            = 4;
    localparam int SPLIT_BITS      = HIST_BITS / 2;
    localparam int HI_BITS         = HIST_BITS - SPLIT_BITS;
    localparam int XPROD_W         = SAMPLE_BITS + GAIN_BITS + 1;
    localparam int FBPROD_W        = COEF_BITS + HIST_BITS;
    localparam int TERM_W          = FBPROD_W - COEF_FRAC;
    localparam int ACC_W           = TERM_W + 4;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = GAIN_BITS;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [HIST_BITS-1:0]   t_hist;
    typedef logic signed [COEF_BITS-1:0]   t_coef;
    typedef logic signed [TERM_W-1:0]      t_term;
    typedef logic signed [ACC_W-1:0]       t_acc;
    typedef logic signed [XPROD_W-1:0]     t_xprod;
    typedef logic [GAIN_BITS-1:0]          t_gain;
    typedef logic [CFG_IDX_W-1:0]          t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0]         t_cfg_data;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INV_GAIN  = 3'd0,
        REG_FB_COEF_0 = 3'd1,
        REG_FB_COEF_1 = 3'd2,
        REG_FB_COEF_2 = 3'd3,
        REG_FB_COEF_3 = 3'd4
    } t_cfg_reg;

    function automatic t_hist sat_xprod(input t_xprod v);
        logic [XPROD_W-HIST_BITS:0] top;
        top = v[XPROD_W-1:HIST_BITS-1];
        if (&top || ~|top) begin
            return v[HIST_BITS-1:0];
        end else begin
            return {v[XPROD_W-1], {(HIST_BITS-1){~v[XPROD_W-1]}}};
        end
    endfunction

    function automatic t_hist sat_acc(input t_acc v);
        logic [ACC_W-HIST_BITS:0] top;
        top = v[ACC_W-1:HIST_BITS-1];
        if (&top || ~|top) begin
            return v[HIST_BITS-1:0];
        end else begin
            return {v[ACC_W-1], {(HIST_BITS-1){~v[ACC_W-1]}}};
        end
    endfunction

    function automatic t_sample sat_sample(input t_hist v);
        logic [HIST_BITS-SAMPLE_BITS:0] top;
        top = v[HIST_BITS-1:SAMPLE_BITS-1];
        if (&top || ~|top) begin
            return v[SAMPLE_BITS-1:0];
        end else begin
            return {v[HIST_BITS-1], {(SAMPLE_BITS-1){~v[HIST_BITS-1]}}};
        end
    endfunction

    // floor(k * y / 2^COEF_FRAC), built from two half-width products
    function automatic t_term fb_term(input t_coef k, input t_hist y);
        logic signed [HI_BITS-1:0]             yh;
        logic signed [SPLIT_BITS:0]            yl;
        logic signed [COEF_BITS+HI_BITS-1:0]   ph;
        logic signed [COEF_BITS+SPLIT_BITS:0]  pl;
        logic signed [FBPROD_W-1:0]            p;
        yh = y[HIST_BITS-1:SPLIT_BITS];
        yl = {1'b0, y[SPLIT_BITS-1:0]};
        ph = (COEF_BITS+HI_BITS)'(k) * (COEF_BITS+HI_BITS)'(yh);
        pl = (COEF_BITS+SPLIT_BITS+1)'(k) * (COEF_BITS+SPLIT_BITS+1)'(yl);
        p  = (FBPROD_W'(ph) <<< SPLIT_BITS) + FBPROD_W'(pl);
        return p[FBPROD_W-1:COEF_FRAC];
    endfunction

endpackage

### rtl/core/butterworth_lowpass_order4.sv
// Fourth-order low-pass IIR filter, one sample in and one sample out per transfer.
// The input register feeds the result register when the output is free. Throughput: one
// sample per cycle unless the output stalls; the scaling multiply sits before the input
// register, the four-tap feedback and saturation before the result register.
// Reset (synchronous, active low) clears gain, coefficients, history and valids.
`timescale 1ns / 1ps
module butterworth_lowpass_order4 (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  bwlp4_pkg::t_sample   i_sample_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output bwlp4_pkg::t_sample   o_sample_out,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  bwlp4_pkg::t_cfg_idx  i_cfg_index,
    input  bwlp4_pkg::t_cfg_data i_cfg_data
);
    import bwlp4_pkg::*;

    t_gain   r_gain;
    t_coef   r_coef [TAPS];
    t_hist   r_ih   [TAPS];
    t_hist   r_oh   [TAPS];
    logic    r_x_vld;
    t_hist   r_x;
    logic    r_out_vld;
    t_sample r_out_sample;

    t_xprod  n_xprod;
    t_hist   n_x;
    t_acc    n_ff;
    t_acc    n_fb;
    t_hist   n_y;
    t_sample n_out_sample;
    logic    in_xfer;
    logic    advance;

    assign advance    = r_x_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_x_vld || advance;
    assign in_xfer    = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_xprod = XPROD_W'($signed(i_sample_in)) * XPROD_W'($signed({1'b0, r_gain}));
        n_x     = sat_xprod(n_xprod >>> (GAIN_BITS - STATE_FRAC_BITS));
    end

    always_comb begin
        t_acc h1p3;
        t_acc h2;
        h1p3 = ACC_W'(r_ih[1]) + ACC_W'(r_ih[3]);
        h2   = ACC_W'(r_ih[2]);
        n_ff = ACC_W'(r_x) + ACC_W'(r_ih[0]) + (h1p3 <<< 2) + (h2 <<< 2) + (h2 <<< 1);
        n_fb = '0;
        for (int i = 0; i < TAPS; i++) begin
            n_fb = n_fb + ACC_W'(fb_term(r_coef[i], r_oh[i]));
        end
        n_y          = sat_acc(n_ff + n_fb);
        n_out_sample = sat_sample(n_y >>> STATE_FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain    <= '0;
            r_x_vld   <= 1'b0;
            r_out_vld <= 1'b0;
            for (int i = 0; i < TAPS; i++) begin
                r_coef[i] <= '0;
                r_ih[i]   <= '0;
                r_oh[i]   <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                case (t_cfg_reg'(i_cfg_index))
                    REG_INV_GAIN:  r_gain    <= i_cfg_data[GAIN_BITS-1:0];
                    REG_FB_COEF_0: r_coef[0] <= i_cfg_data[COEF_BITS-1:0];
                    REG_FB_COEF_1: r_coef[1] <= i_cfg_data[COEF_BITS-1:0];
                    REG_FB_COEF_2: r_coef[2] <= i_cfg_data[COEF_BITS-1:0];
                    REG_FB_COEF_3: r_coef[3] <= i_cfg_data[COEF_BITS-1:0];
                    default: ;
                endcase
            end
            if (in_xfer) begin
                r_x_vld <= 1'b1;
            end else if (advance) begin
                r_x_vld <= 1'b0;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
                for (int i = 0; i < TAPS - 1; i++) begin
                    r_ih[i] <= r_ih[i+1];
                    r_oh[i] <= r_oh[i+1];
                end
                r_ih[TAPS-1] <= r_x;
                r_oh[TAPS-1] <= n_y;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_x <= n_x;
        end
        if (advance) begin
            r_out_sample <= n_out_sample;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_sample_out = r_out_sample;

endmodule

### rtl/core/bwlp4_checker.sv
// Port-level checker for the fourth-order low-pass filter, bound to the top level
`timescale 1ns / 1ps
`include "butterworth_lowpass_order4_macros.svh"
module bwlp4_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input bwlp4_pkg::t_sample o_sample_out
);
    import bwlp4_pkg::*;

    `BWLP4_ASSERT_NXT_ALL(a_rst_empty, !i_rst_n, !o_out_valid, "output valid after reset")
    `BWLP4_ASSERT_IMP(a_empty_ready, !o_out_valid, o_in_ready, "input stalled on empty output")
    `BWLP4_ASSERT_NXT(a_latency, i_in_valid && o_in_ready, ##1 o_out_valid, "result missing")
    `BWLP4_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_sample_out), "stalled output changed")

endmodule

bind butterworth_lowpass_order4 bwlp4_checker u_bwlp4_checker (.*);

### test/testbench.sv
// Testbench for the fourth-order low-pass filter, checked sample by sample against a predictor
`timescale 1ns / 1ps
module testbench;
    import bwlp4_pkg::*;

    localparam int LATENCY        = 2;
    localparam int HOLD_CYCLES    = 80;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int BINOM_1        = 4;
    localparam int BINOM_2        = 6;
    localparam int CFG_IDX_TOP    = (1 << CFG_IDX_W) - 1;

    localparam t_sample SAMPLE_MAX = 16'sh7FFF;
    localparam t_sample SAMPLE_MIN = 16'sh8000;
    localparam t_coef   COEF_MAX   = 32'sh7FFF_FFFF;
    localparam t_coef   COEF_MIN   = 32'sh8000_0000;
    localparam t_gain   GAIN_MAX   = '1;

    localparam t_gain BW_GAIN = 40'd5305000000;
    localparam t_coef BW_FB0  = -32'sd50304804;
    localparam t_coef BW_FB1  = 32'sd283118876;
    localparam t_coef BW_FB2  = -32'sd621159645;
    localparam t_coef BW_FB3  = 32'sd636057813;

    typedef logic signed [95:0] t_wide;

    logic       i_clk;
    logic       i_rst_n;
    logic       in_valid;
    logic       in_ready;
    t_sample    in_sample;
    logic       out_valid;
    logic       out_ready;
    t_sample    out_sample;
    logic       cfg_valid;
    logic       cfg_ready;
    t_cfg_idx   cfg_index;
    t_cfg_data  cfg_data;

    t_gain   gain_q40;
    t_coef   fb_q28 [TAPS];
    t_wide   x_hist [TAPS];
    t_wide   y_hist [TAPS];
    t_sample expected_samples [$];

    int  errors;
    int  n_sent;
    int  n_checked;
    int  n_settings;
    int  stall_cycles;
    bit  tx_idle_on;
    bit  rx_idle_on;
    bit  hold_request;

    butterworth_lowpass_order4 dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_sample_in  (in_sample),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_sample_out (out_sample),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic t_wide clamp(input t_wide v, input int bits);
        t_wide hi;
        t_wide lo;
        hi = (t_wide'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin
            return hi;
        end else if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

    function automatic t_sample filter_step(input t_sample s);
        t_wide x;
        t_wide y;
        int    i;
        x = clamp((t_wide'(s) * t_wide'(gain_q40)) >>> (GAIN_BITS - STATE_FRAC_BITS), HIST_BITS);
        y = x_hist[0] + x + BINOM_1 * (x_hist[1] + x_hist[3]) + BINOM_2 * x_hist[2];
        for (i = 0; i < TAPS; i++) begin
            y = y + ((t_wide'(fb_q28[i]) * y_hist[i]) >>> COEF_FRAC);
        end
        y = clamp(y, HIST_BITS);
        for (i = 0; i < TAPS - 1; i++) begin
            x_hist[i] = x_hist[i + 1];
            y_hist[i] = y_hist[i + 1];
        end
        x_hist[TAPS - 1] = x;
        y_hist[TAPS - 1] = y;
        return t_sample'(clamp(y >>> STATE_FRAC_BITS, SAMPLE_BITS));
    endfunction

    function automatic void apply_reg(input t_cfg_idx idx, input t_cfg_data data);
        case (idx)
            REG_INV_GAIN:  gain_q40  = data;
            REG_FB_COEF_0: fb_q28[0] = data[COEF_BITS-1:0];
            REG_FB_COEF_1: fb_q28[1] = data[COEF_BITS-1:0];
            REG_FB_COEF_2: fb_q28[2] = data[COEF_BITS-1:0];
            REG_FB_COEF_3: fb_q28[3] = data[COEF_BITS-1:0];
            default: ;
        endcase
    endfunction

    function automatic t_sample random_sample();
        case ($urandom_range(0, 9))
            0: return ($urandom_range(0, 1) != 0) ? SAMPLE_MAX : SAMPLE_MIN;
            1, 2: return t_sample'(int'($urandom_range(0, 255)) - 128);
            default: return t_sample'($urandom);
        endcase
    endfunction

    function automatic t_gain random_gain();
        case ($urandom_range(0, 3))
            0: return BW_GAIN;
            1: return t_gain'({$urandom, $urandom});
            2: return t_gain'({$urandom_range(0, 1), $urandom});
            default: return GAIN_MAX;
        endcase
    endfunction

    function automatic t_coef random_coef(input int kind, input t_coef base);
        case (kind)
            0: return base + t_coef'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
            1: return t_coef'(int'($urandom_range(0, 1 << 27)) - (1 << 26));
            2: return t_coef'($urandom);
            default: return ($urandom_range(0, 1) != 0) ? COEF_MAX : COEF_MIN;
        endcase
    endfunction

    task automatic send_sample(input t_sample s);
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        in_valid  <= 1'b1;
        in_sample <= s;
        do @(posedge i_clk); while (!in_ready);
        expected_samples.push_back(filter_step(s));
        n_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_samples.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 2) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input t_cfg_data data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge i_clk); while (!cfg_ready);
        apply_reg(idx, data);
        @(negedge i_clk);
    endtask

    task automatic program_filter(input t_gain g, input t_coef c0, input t_coef c1,
                                  input t_coef c2, input t_coef c3);
        drain();
        write_reg(REG_INV_GAIN, g);
        write_reg(REG_FB_COEF_0, t_cfg_data'({8'($urandom), c0}));
        write_reg(REG_FB_COEF_1, t_cfg_data'({8'($urandom), c1}));
        write_reg(REG_FB_COEF_2, t_cfg_data'({8'($urandom), c2}));
        write_reg(REG_FB_COEF_3, t_cfg_data'({8'($urandom), c3}));
        write_reg(t_cfg_idx'($urandom_range(REG_FB_COEF_3 + 1, CFG_IDX_TOP)),
                  t_cfg_data'({$urandom, $urandom}));
        cfg_valid <= 1'b0;
        n_settings++;
        @(negedge i_clk);
    endtask

    task automatic test_reset_defaults();
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);
        send_sample(-16'sd1);
        send_sample(16'sd0);
    endtask

    task automatic test_input_extremes();
        program_filter(GAIN_MAX, '0, '0, '0, '0);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MIN);
        send_sample(16'sh5555);
        send_sample(16'shAAAA);
    endtask

    task automatic test_feedback_saturation();
        program_filter(GAIN_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
        repeat (5) send_sample(SAMPLE_MAX);
        program_filter(GAIN_MAX, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
        repeat (4) send_sample(SAMPLE_MIN);
    endtask

    task automatic test_zero_gain_ringout();
        program_filter(BW_GAIN, BW_FB0, BW_FB1, BW_FB2, BW_FB3);
        repeat (2) send_sample(SAMPLE_MAX);
        program_filter('0, BW_FB0, BW_FB1, BW_FB2, BW_FB3);
        repeat (4) send_sample(16'sd0);
    endtask

    task automatic test_random_settings();
        int phase;
        int kind;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        for (phase = 0; phase < 12; phase++) begin
            kind = phase % 4;
            program_filter(random_gain(), random_coef(kind, BW_FB0), random_coef(kind, BW_FB1),
                           random_coef(kind, BW_FB2), random_coef(kind, BW_FB3));
            repeat (60) send_sample(random_sample());
        end
    endtask

    task automatic test_output_stall();
        program_filter(BW_GAIN, BW_FB0, BW_FB1, BW_FB2, BW_FB3);
        tx_idle_on   = 1'b0;
        hold_request = 1'b1;
        repeat (40) send_sample(random_sample());
        tx_idle_on = 1'b1;
    endtask

    task automatic test_lowpass_stream();
        program_filter(BW_GAIN, random_coef(0, BW_FB0), random_coef(0, BW_FB1),
                       random_coef(0, BW_FB2), random_coef(0, BW_FB3));
        repeat (400) send_sample(random_sample());
    endtask

    task automatic test_closing_burst();
        program_filter(random_gain(), random_coef(1, BW_FB0), random_coef(1, BW_FB1),
                       random_coef(1, BW_FB2), random_coef(1, BW_FB3));
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        repeat (150) send_sample(random_sample());
    endtask

    initial begin
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                out_ready    <= 1'b0;
                hold_request = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 6) - 1) @(negedge i_clk);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready) begin
            if (expected_samples.size() == 0) begin
                $display("%0t: unexpected sample_out transfer, got %0d", $time, out_sample);
                errors++;
            end else begin
                if (out_sample !== expected_samples[0]) begin
                    $display("%0t: sample_out mismatch, expected %0d, got %0d",
                             $time, expected_samples[0], out_sample);
                    errors++;
                end
                void'(expected_samples.pop_front());
                n_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || (in_valid && in_ready) || (out_valid && out_ready)
                || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d samples outstanding",
                     $time, WATCHDOG_LIMIT, expected_samples.size());
            $display("DONE: errors detected");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        in_valid     = 1'b0;
        in_sample    = '0;
        out_ready    = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        gain_q40     = '0;
        errors       = 0;
        n_sent       = 0;
        n_checked    = 0;
        n_settings   = 0;
        stall_cycles = 0;
        tx_idle_on   = 1'b0;
        rx_idle_on   = 1'b0;
        hold_request = 1'b0;
        for (int i = 0; i < TAPS; i++) begin
            fb_q28[i] = '0;
            x_hist[i] = '0;
            y_hist[i] = '0;
        end
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_input_extremes();
        test_feedback_saturation();
        test_zero_gain_ringout();
        test_random_settings();
        test_output_stall();
        test_lowpass_stream();
        test_closing_burst();
        drain();

        $display("Run covered %0d samples, %0d checked, over %0d register settings,",
                 n_sent, n_checked, n_settings);
        $display("with gain and feedback extremes, ignored indexes and a long output stall.");
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
